// ----- rtl/bpa_pkg.sv -----
`timescale 1ns / 1ps

package bpa_pkg;

   localparam int DefMaxOrder  = 6;
   localparam int DefTopBlocks = 4;
   localparam int DefPageShift = 12;

   localparam logic ActAlloc = 1'b0;
   localparam logic ActFree  = 1'b1;

   typedef struct packed {
      logic        action;
      logic [31:0] size_bytes;
      logic [7:0]  page_index;
   } req_type;

   typedef struct packed {
      logic       ok;
      logic [7:0] block_page;
      logic [2:0] block_order;
   } rsp_type;

endpackage

// ----- rtl/buddy_page_allocator_unit.sv -----
`timescale 1ns / 1ps
// An allocation sizes the request, scans the orders upward for a free block, unlinks it and
// splits it down, listing each split-off half; a free merges the block with its free buddy
// order by order and then lists it. One item is in work at a time; the link memories'
// single read port and the split or merge walk over the orders keep a new item out until then.
// Reset: synchronous; a clearing pass over every page then rebuilds the link memories.
module buddy_page_allocator_unit
   import bpa_pkg::*;
#(
   parameter int TOP_ORDER  = DefMaxOrder,
   parameter int TOP_BLOCKS = DefTopBlocks,
   parameter int PAGE_SHIFT = DefPageShift
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // Pool geometry. A page id has one code beyond the pool, the null link.
   localparam int POOL = TOP_BLOCKS << TOP_ORDER;
   localparam int PW   = $clog2(POOL + 1);
   localparam int IW   = $clog2(POOL);
   localparam int OW   = $clog2(TOP_ORDER + 1);
   localparam int BLK  = 1 << TOP_ORDER;
   localparam logic [PW-1:0] NIL = PW'(POOL);

   localparam logic [3:0] S_IDLE = 4'd0, S_INIT = 4'd1, S_LG = 4'd2, S_SCAN = 4'd3,
                          S_RD = 4'd4, S_UL_A = 4'd5, S_UL_B = 4'd6, S_SP_TOP = 4'd7,
                          S_PU_A = 4'd8, S_PU_B = 4'd9, S_FR_CHK = 4'd10, S_M_TOP = 4'd11,
                          S_M_CHK = 4'd12, S_M_UPD = 4'd13, S_RESP = 4'd14;

   // Which walk a shared unlink or push belongs to.
   localparam logic [1:0] PH_ALLOC = 2'd0, PH_FREE = 2'd1, PH_MERGE = 2'd2;

   logic [3:0]    state_ff, state_in;
   logic [IW-1:0] cnt_ff, cnt_in;
   logic [31:0]   m_ff, m_in;
   logic [5:0]    lg_ff, lg_in;
   logic [OW-1:0] o_ff, o_in, want_ff, want_in;
   logic [PW-1:0] blk_ff, blk_in, ul_ff, ul_in, h_ff, h_in;
   logic [1:0]    phase_ff, phase_in;
   rsp_type       res_ff, res_in;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_data_ff, rsp_data_in;
   logic [PW-1:0] head_ff [TOP_ORDER+1];
   logic [PW-1:0] head_in [TOP_ORDER+1];

   // Link memories, one entry per page, read at the page being worked on.
   logic [PW-1:0] next_mem [POOL];
   logic [PW-1:0] prev_mem [POOL];
   logic [OW-1:0] order_mem [POOL];
   logic          listed_mem [POOL];
   logic [PW-1:0] rd_next_ff, rd_prev_ff;
   logic [OW-1:0] rd_order_ff;
   logic          rd_listed_ff;

   logic          nx_we, pv_we, od_we, ls_we;
   logic [IW-1:0] nx_wa, pv_wa, od_wa, ls_wa;
   logic [PW-1:0] nx_wd, pv_wd;
   logic [OW-1:0] od_wd;
   logic          ls_wd;

   logic          init_head;
   logic [31:0]   init_next;
   logic [5:0]    lg_fin, want6;
   logic [PW-1:0] pu_page, bud, merged;

   always_ff @(posedge clock) begin
      if (nx_we) next_mem[nx_wa] <= nx_wd;
      if (pv_we) prev_mem[pv_wa] <= pv_wd;
      if (od_we) order_mem[od_wa] <= od_wd;
      if (ls_we) listed_mem[ls_wa] <= ls_wd;
      rd_next_ff   <= next_mem[ul_ff[IW-1:0]];
      rd_prev_ff   <= prev_mem[ul_ff[IW-1:0]];
      rd_order_ff  <= order_mem[ul_ff[IW-1:0]];
      rd_listed_ff <= listed_mem[ul_ff[IW-1:0]];
   end

   always_comb begin
      init_head = (cnt_ff[TOP_ORDER-1:0] == '0);
      init_next = 32'(cnt_ff) + 32'(BLK);
      lg_fin    = lg_ff + (m_ff[1] ? 6'd2 : {5'd0, m_ff[0]});
      want6     = (lg_fin > 6'(PAGE_SHIFT)) ? lg_fin - 6'(PAGE_SHIFT) : 6'd0;
      pu_page   = (phase_ff == PH_ALLOC) ? (blk_ff ^ (PW'(1) << o_ff)) : blk_ff;
      bud       = blk_ff ^ (PW'(1) << o_ff);
      merged    = (ul_ff < blk_ff) ? ul_ff : blk_ff;
   end

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      m_in     = m_ff;
      lg_in    = lg_ff;
      o_in     = o_ff;
      want_in  = want_ff;
      blk_in   = blk_ff;
      ul_in    = ul_ff;
      h_in     = h_ff;
      phase_in = phase_ff;
      res_in   = res_ff;
      head_in  = head_ff;
      nx_we = 1'b0; nx_wa = ul_ff[IW-1:0]; nx_wd = NIL;
      pv_we = 1'b0; pv_wa = ul_ff[IW-1:0]; pv_wd = NIL;
      od_we = 1'b0; od_wa = ul_ff[IW-1:0]; od_wd = o_ff;
      ls_we = 1'b0; ls_wa = ul_ff[IW-1:0]; ls_wd = 1'b0;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      unique case (state_ff)
         S_INIT: begin
            // Top block heads are chained in ascending order, all else is null.
            nx_we = 1'b1; pv_we = 1'b1; od_we = 1'b1; ls_we = 1'b1;
            nx_wa = cnt_ff; pv_wa = cnt_ff; od_wa = cnt_ff; ls_wa = cnt_ff;
            nx_wd = (init_head && init_next < 32'(POOL)) ? PW'(init_next) : NIL;
            pv_wd = (init_head && cnt_ff != '0) ? PW'(cnt_ff) - PW'(BLK) : NIL;
            od_wd = init_head ? OW'(TOP_ORDER) : '0;
            ls_wd = init_head;
            cnt_in = cnt_ff + IW'(1);
            if (cnt_ff == IW'(POOL - 1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_data.action == ActAlloc) begin
                  m_in     = (req_data.size_bytes <= 32'd1) ? 32'd0 : req_data.size_bytes - 32'd1;
                  lg_in    = '0;
                  phase_in = PH_ALLOC;
                  state_in = S_LG;
               end else if (32'(req_data.page_index) < 32'(POOL)) begin
                  blk_in   = PW'(req_data.page_index);
                  ul_in    = PW'(req_data.page_index);
                  phase_in = PH_FREE;
                  state_in = S_RD;
               end else begin
                  state_in = S_RESP;
               end
            end
         end
         S_LG: begin
            // Ceiling log2 of the size, two bits a cycle.
            if (m_ff[31:2] != '0) begin
               m_in  = m_ff >> 2;
               lg_in = lg_ff + 6'd2;
            end else if (want6 > 6'(TOP_ORDER)) begin
               state_in = S_RESP;
            end else begin
               want_in  = OW'(want6);
               o_in     = OW'(want6);
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            if (head_ff[o_ff] != NIL) begin
               blk_in   = head_ff[o_ff];
               ul_in    = head_ff[o_ff];
               state_in = S_RD;
            end else if (o_ff == OW'(TOP_ORDER)) begin
               state_in = S_RESP;
            end else begin
               o_in = o_ff + OW'(1);
            end
         end
         S_RD: begin
            unique case (phase_ff)
               PH_ALLOC: state_in = S_UL_A;
               PH_FREE:  state_in = S_FR_CHK;
               default:  state_in = S_M_CHK;
            endcase
         end
         S_UL_A: begin
            // Bridge the neighbors of the page leaving its list.
            if (rd_prev_ff != NIL) begin
               nx_we = 1'b1; nx_wa = rd_prev_ff[IW-1:0]; nx_wd = rd_next_ff;
            end else if (head_ff[rd_order_ff] == ul_ff) begin
               head_in[rd_order_ff] = rd_next_ff;
            end
            if (rd_next_ff != NIL) begin
               pv_we = 1'b1; pv_wa = rd_next_ff[IW-1:0]; pv_wd = rd_prev_ff;
            end
            ls_we = 1'b1;
            state_in = S_UL_B;
         end
         S_UL_B: begin
            nx_we = 1'b1;
            pv_we = 1'b1;
            unique case (phase_ff)
               PH_ALLOC: state_in = S_SP_TOP;
               PH_FREE:  state_in = S_M_TOP;
               default:  state_in = S_M_UPD;
            endcase
         end
         S_SP_TOP: begin
            if (o_ff > want_ff) begin
               o_in     = o_ff - OW'(1);
               state_in = S_PU_A;
            end else begin
               od_we = 1'b1; od_wa = blk_ff[IW-1:0]; od_wd = want_ff;
               res_in.ok          = 1'b1;
               res_in.block_page  = 8'(blk_ff);
               res_in.block_order = 3'(want_ff);
               state_in = S_RESP;
            end
         end
         S_PU_A: begin
            // List the page at the head of its order.
            od_we = 1'b1; od_wa = pu_page[IW-1:0]; od_wd = o_ff;
            pv_we = 1'b1; pv_wa = pu_page[IW-1:0]; pv_wd = NIL;
            nx_we = 1'b1; nx_wa = pu_page[IW-1:0]; nx_wd = head_ff[o_ff];
            ls_we = 1'b1; ls_wa = pu_page[IW-1:0]; ls_wd = 1'b1;
            h_in  = head_ff[o_ff];
            ul_in = pu_page;
            head_in[o_ff] = pu_page;
            state_in = S_PU_B;
         end
         S_PU_B: begin
            if (h_ff != NIL) begin
               pv_we = 1'b1; pv_wa = h_ff[IW-1:0]; pv_wd = ul_ff;
            end
            if (phase_ff == PH_ALLOC) begin
               state_in = S_SP_TOP;
            end else begin
               res_in.ok          = 1'b1;
               res_in.block_page  = 8'(blk_ff);
               res_in.block_order = 3'(o_ff);
               state_in = S_RESP;
            end
         end
         S_FR_CHK: begin
            o_in = rd_order_ff;
            state_in = rd_listed_ff ? S_UL_A : S_M_TOP;
         end
         S_M_TOP: begin
            if (o_ff < OW'(TOP_ORDER)) begin
               ul_in    = bud;
               phase_in = PH_MERGE;
               state_in = S_RD;
            end else begin
               state_in = S_PU_A;
            end
         end
         S_M_CHK: begin
            state_in = (rd_listed_ff && rd_order_ff == o_ff) ? S_UL_A : S_PU_A;
         end
         S_M_UPD: begin
            blk_in = merged;
            o_in   = o_ff + OW'(1);
            od_we = 1'b1; od_wa = merged[IW-1:0]; od_wd = o_ff + OW'(1);
            state_in = S_M_TOP;
         end
         S_RESP: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_data_in  = res_ff;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i <= TOP_ORDER; i++) begin
            head_ff[i] <= (i == TOP_ORDER) ? '0 : NIL;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         head_ff      <= head_in;
      end
      m_ff        <= m_in;
      lg_ff       <= lg_in;
      o_ff        <= o_in;
      want_ff     <= want_in;
      blk_ff      <= blk_in;
      ul_ff       <= ul_in;
      h_ff        <= h_in;
      phase_ff    <= phase_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

   // Items enter only while the unit is idle: not during the clearing pass, a walk or the response step.
   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A failed item carries a cleared page and order.
   a_fail_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.ok |-> rsp_data.block_page == 8'd0 && rsp_data.block_order == 3'd0)
      else $error("failed item carries nonzero page or order");

   // No result order ever exceeds the largest order.
   a_order_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.block_order) <= 32'(TOP_ORDER))
      else $error("result order beyond largest order");

   // A merge step only runs below the largest order.
   a_merge_order: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_M_UPD |-> 32'(o_ff) < 32'(TOP_ORDER))
      else $error("merge step at largest order");

   // A result register is loaded only on leaving the response step.
   a_load_from_resp: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff) == S_RESP)
      else $error("result appeared outside response step");

endmodule

// ----- tb/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
   import bpa_pkg::*;

   localparam int MaxOrd    = DefMaxOrder;
   localparam int TopBlk    = DefTopBlocks;
   localparam int PgShift   = DefPageShift;
   localparam int PoolPages = TopBlk << MaxOrd;
   localparam int Nil       = PoolPages;
   localparam int CycleLimit = 400000;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   buddy_page_allocator_unit u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   // Shadow copy of the allocator's free lists and per-page bookkeeping.
   int unsigned free_head[MaxOrd+1];
   int unsigned link_next[PoolPages];
   int unsigned link_prev[PoolPages];
   int unsigned pg_order[PoolPages];
   bit          pg_listed[PoolPages];

   req_type pending_items[$];
   rsp_type expected_rsps[$];
   int unsigned live_pages[$];
   int errors;
   int cycles;
   bit stim_done;
   int burst_left, gap_left;

   // Takes a page off whatever list its order points at.
   function automatic void list_remove(int unsigned p);
      int unsigned o, n, v;
      o = pg_order[p];
      n = link_next[p];
      v = link_prev[p];
      if (o > MaxOrd) o = MaxOrd;
      if (v != Nil) link_next[v] = n;
      else if (free_head[o] == p) free_head[o] = n;
      if (n != Nil) link_prev[n] = v;
      link_next[p] = Nil;
      link_prev[p] = Nil;
      pg_listed[p] = 0;
   endfunction

   function automatic void list_insert(int unsigned p, int unsigned o);
      int unsigned h;
      h = free_head[o];
      pg_order[p] = o;
      link_prev[p] = Nil;
      link_next[p] = h;
      if (h != Nil) link_prev[h] = p;
      free_head[o] = p;
      pg_listed[p] = 1;
   endfunction

   function automatic void pool_reset();
      for (int i = 0; i <= MaxOrd; i++) free_head[i] = Nil;
      for (int i = 0; i < PoolPages; i++) begin
         link_next[i] = Nil;
         link_prev[i] = Nil;
         pg_order[i] = 0;
         pg_listed[i] = 0;
      end
      for (int i = TopBlk; i > 0; i--) list_insert((i - 1) << MaxOrd, MaxOrd);
   endfunction

   // Computes the response an item will produce and updates the shadow pool.
   function automatic rsp_type predict_block(req_type it);
      rsp_type r;
      int unsigned lg, want, o, blk, bud;
      longint unsigned sz;
      r = '0;
      if (it.action == ActAlloc) begin
         sz = it.size_bytes;
         lg = 0;
         while (lg < 40 && (64'd1 << lg) < sz) lg++;
         want = (lg > PgShift) ? lg - PgShift : 0;
         if (want <= MaxOrd) begin
            o = want;
            while (o <= MaxOrd && free_head[o] == Nil) o++;
            if (o <= MaxOrd) begin
               blk = free_head[o];
               list_remove(blk);
               while (o > want) begin
                  o--;
                  list_insert(blk ^ (1 << o), o);
               end
               pg_order[blk] = want;
               r.ok = 1'b1;
               r.block_page = blk[7:0];
               r.block_order = want[2:0];
            end
         end
      end else if (it.page_index < PoolPages) begin
         blk = it.page_index;
         if (pg_listed[blk]) list_remove(blk);
         o = pg_order[blk];
         while (o < MaxOrd) begin
            bud = blk ^ (1 << o);
            if (bud >= PoolPages || !pg_listed[bud] || pg_order[bud] != o) break;
            list_remove(bud);
            if (bud < blk) blk = bud;
            o++;
            pg_order[blk] = o;
         end
         if (o > MaxOrd) o = MaxOrd;
         list_insert(blk, o);
         r.ok = 1'b1;
         r.block_page = blk[7:0];
         r.block_order = o[2:0];
      end
      return r;
   endfunction

   function automatic req_type make_alloc(logic [31:0] sz);
      req_type it;
      it.action = ActAlloc;
      it.size_bytes = sz;
      it.page_index = 8'($urandom);
      return it;
   endfunction

   function automatic req_type make_free(logic [7:0] pg);
      req_type it;
      it.action = ActFree;
      it.size_bytes = $urandom;
      it.page_index = pg;
      return it;
   endfunction

   // Random allocation size, mostly within the page orders the pool can serve.
   function automatic logic [31:0] rand_size();
      int unsigned k;
      k = $urandom_range(0, 9);
      if (k == 0) return $urandom;
      if (k == 1) return $urandom_range(0, 4096);
      return $urandom_range(1, 1 << (PgShift + $urandom_range(0, MaxOrd)));
   endfunction

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      int unsigned pg;
      // Directed items: size extremes, rounding edges, oversize, exhaustion, and
      // frees of unallocated pages and of listed block heads.
      pending_items.push_back(make_alloc(32'd0));
      pending_items.push_back(make_alloc(32'd1));
      pending_items.push_back(make_alloc(32'd4096));
      pending_items.push_back(make_alloc(32'd4097));
      pending_items.push_back(make_alloc(32'd262144));
      pending_items.push_back(make_alloc(32'd262145));
      pending_items.push_back(make_alloc(32'hFFFF_FFFF));
      pending_items.push_back(make_free(8'd0));
      pending_items.push_back(make_free(8'd4));
      pending_items.push_back(make_free(8'd255));
      pending_items.push_back(make_free(8'd200));
      pending_items.push_back(make_free(8'd1));
      pending_items.push_back(make_free(8'd128));
      pending_items.push_back(make_free(8'd192));
      for (int i = 0; i < 5; i++) pending_items.push_back(make_alloc(32'd262144));
      for (int i = 0; i < 4; i++) pending_items.push_back(make_free(8'(i * 64)));
      // Random part: allocations and frees of guessed pages, with some noise.
      // The page list is a guess kept only for stimulus shaping.
      for (int i = 0; i < 600; i++) begin
         if (live_pages.size() == 0 || $urandom_range(0, 9) < 5) begin
            pending_items.push_back(make_alloc(rand_size()));
            live_pages.push_back($urandom_range(0, PoolPages - 1));
         end else if ($urandom_range(0, 9) < 8) begin
            pg = $urandom_range(0, live_pages.size() - 1);
            pending_items.push_back(make_free(live_pages[pg][7:0]));
            live_pages.delete(pg);
         end else begin
            pending_items.push_back(make_free(8'($urandom)));
         end
      end
      stim_done = 1'b1;
   end

   // Successful responses steer later frees: the driver replaces a random
   // fraction of free page numbers with pages actually granted.
   int unsigned granted[$];

   // Driver: bursts of items separated by random gaps.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data <= '0;
         burst_left <= $urandom_range(1, 20);
         gap_left <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            expected_rsps.push_back(predict_block(req_data));
         end
         if (!req_valid || !req_stall) begin
            if (gap_left > 0) begin
               gap_left <= gap_left - 1;
               req_valid <= 1'b0;
            end else if (pending_items.size() > 0) begin
               req_type nx;
               nx = pending_items.pop_front();
               if (nx.action == ActFree && granted.size() > 0 && $urandom_range(0, 1))
                  nx.page_index = 8'(granted[$urandom_range(0, granted.size() - 1)]);
               req_valid <= 1'b1;
               req_data <= nx;
               if (burst_left <= 1) begin
                  burst_left <= $urandom_range(1, 20);
                  gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
               end else begin
                  burst_left <= burst_left - 1;
               end
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Receiver stall pattern: long open stretches mixed with random stalls.
   always @(posedge clock) begin
      if (reset) rsp_stall <= 1'b0;
      else if ((cycles / 500) % 3 == 0) rsp_stall <= 1'b0;
      else rsp_stall <= ($urandom_range(0, 3) == 0);
   end

   // Monitor: compare each accepted response with the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsps.size() == 0) begin
            $error("unexpected response item %p", rsp_data);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsps.pop_front();
            if (rsp_data.ok !== e.ok) begin
               $error("ok: expected %0d actual %0d", e.ok, rsp_data.ok);
               errors++;
            end
            if (rsp_data.block_page !== e.block_page) begin
               $error("block_page: expected %0d actual %0d", e.block_page,
                      rsp_data.block_page);
               errors++;
            end
            if (rsp_data.block_order !== e.block_order) begin
               $error("block_order: expected %0d actual %0d", e.block_order,
                      rsp_data.block_order);
               errors++;
            end
            if (e.ok && rsp_data.ok === 1'b1 && granted.size() < 64)
               granted.push_back(32'(e.block_page));
            else if (granted.size() >= 64)
               granted.delete(0);
         end
      end
   end

   // Watchdog on total cycles.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   initial begin
      errors = 0;
      cycles = 0;
      pool_reset();
      reset = 1'b1;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      // Wait for all items to be sent and every prediction to be matched.
      wait (stim_done);
      @(posedge clock);
      while (pending_items.size() > 0 || req_valid || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (100) @(posedge clock);
      if (errors == 0 && expected_rsps.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
